/* sv/kcl_pkg.sv */
`timescale 1ns / 1ps

package kcl_pkg;

  // Key codes
  localparam int KEY_W = 4;
  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_CLEAR     = 4'd10;
  localparam logic [KEY_W-1:0] KEY_BACK      = 4'd11;

  // Result fields
  localparam int TRIES_W = 4;
  localparam int SEG_W   = 8;
  localparam logic [TRIES_W-1:0] TRIES_RESET = 4'd5;
  localparam logic [TRIES_W-1:0] TRIES_MAX   = 4'd9;
  localparam logic [TRIES_W-1:0] TRIES_MIN   = 4'd1;

  // Configuration port
  localparam int SECRET_W    = 16;
  localparam int MAX_TRIES_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECRET_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES   = 1'd1;

  localparam int CODE_DIGITS_DEFAULT = 4;

  // 10^n, elaboration-time use only (n is small)
  function automatic int unsigned pow10(input int n);
    int unsigned r;
    r = 1;
    for (int k = 0; k < n; k++) begin
      r = r * 10;
    end
    return r;
  endfunction

  // Active-low seven-segment pattern, segment a in bit 0, dp in bit 7
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [TRIES_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

endpackage

/* sv/keypad_code_lock_core.sv */
`timescale 1ns / 1ps

// Keypad code lock core.
// Input channel: one key_code transaction per scan tick (in_valid/in_stall);
//   0-9 digit, 10 clears the entry, 11 backspace, 12-15 no key.
// Output channel: exactly one result transaction per key (out_valid/out_stall):
//   segments (active-low digit of tries left), unlock_pulse, locked_out and
//   tries_remaining.
// Path: an accepted key is captured in the input register, and its result is
//   loaded into the output register when that key advances out of it.
// Throughput: one key per cycle when not stalled, set by combinational entry
//   update and CODE_DIGITS-digit compare between input and result registers.
// Stall: when out_stall holds a result, the next key waits in the input
//   register and in_stall rises only once that register is also full.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 secret_code, 1 max_tries.
//   A secret_code write raises in_stall while the code is reduced modulo
//   10^CODE_DIGITS; register writes never touch the entry.
// Reset (rst, synchronous): empty entry, five tries, secret code 0,
//   max_tries 5, both channels empty.
module keypad_code_lock_core #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kcl_pkg::KEY_W-1:0]       key_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kcl_pkg::SEG_W-1:0]       segments,
  output logic                            unlock_pulse,
  output logic                            locked_out,
  output logic [kcl_pkg::TRIES_W-1:0]     tries_remaining
);

  localparam int MOD_W = $clog2(kcl_pkg::pow10(CODE_DIGITS));

  logic                        cfg_busy;
  logic [MOD_W-1:0]            secret_mod;  // secret code mod 10^CODE_DIGITS
  logic [kcl_pkg::TRIES_W-1:0] restore;     // tries after a correct code

  kcl_config #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_config (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (cfg_busy),
    .secret_mod (secret_mod),
    .restore    (restore)
  );

  kcl_engine #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .key_code        (key_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .segments        (segments),
    .unlock_pulse    (unlock_pulse),
    .locked_out      (locked_out),
    .tries_remaining (tries_remaining),
    .cfg_busy        (cfg_busy),
    .secret_mod      (secret_mod),
    .restore         (restore)
  );

endmodule

/* sv/kcl_config.sv */
`timescale 1ns / 1ps

// Configuration registers. The secret code is reduced modulo 10^CODE_DIGITS
// after a write: quotient by reciprocal multiply, then remainder.
module kcl_config #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEFAULT
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]               cfg_data,
  output logic                                         busy,
  output logic [$clog2(kcl_pkg::pow10(CODE_DIGITS))-1:0] secret_mod,
  output logic [kcl_pkg::TRIES_W-1:0]                  restore
);

  localparam int unsigned MOD_BASE = kcl_pkg::pow10(CODE_DIGITS);
  localparam int MOD_W = $clog2(MOD_BASE);
  localparam int SHIFT = kcl_pkg::SECRET_W + $clog2(MOD_BASE);
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(MOD_BASE) - 1) / longint'(MOD_BASE);
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W = kcl_pkg::SECRET_W + RECIP_W;
  localparam int MAX_TRIES_W_L = kcl_pkg::MAX_TRIES_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_QUOT = 2'd1;
  localparam logic [1:0] PH_REM  = 2'd2;

  logic [1:0]                   phase;
  logic [kcl_pkg::SECRET_W-1:0] raw;
  logic [kcl_pkg::SECRET_W-1:0] quot;
  logic [PROD_W-1:0]            prod;
  logic [31:0]                  rem_full;
  logic [MAX_TRIES_W_L-1:0]     max_in;

  assign max_in   = cfg_data[MAX_TRIES_W_L-1:0];
  assign prod     = PROD_W'(raw) * PROD_W'(RECIP);
  assign rem_full = 32'(raw) - 32'(quot) * 32'(MOD_BASE);
  assign busy     = (phase != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      secret_mod <= '0;
      restore    <= kcl_pkg::TRIES_RESET;
    end else begin
      if (cfg_we && cfg_index == kcl_pkg::CFG_SECRET_CODE) begin
        // a new code restarts the reduction
        raw   <= cfg_data[kcl_pkg::SECRET_W-1:0];
        phase <= PH_QUOT;
      end else begin
        case (phase)
          PH_QUOT: begin
            quot  <= kcl_pkg::SECRET_W'(prod >> SHIFT);
            phase <= PH_REM;
          end
          PH_REM: begin
            secret_mod <= rem_full[MOD_W-1:0];
            phase      <= PH_IDLE;
          end
          default: phase <= PH_IDLE;
        endcase
      end
      if (cfg_we && cfg_index == kcl_pkg::CFG_MAX_TRIES) begin
        // saturate high, never restore zero tries
        if (max_in > kcl_pkg::TRIES_MAX) begin
          restore <= kcl_pkg::TRIES_MAX;
        end else if (max_in == '0) begin
          restore <= kcl_pkg::TRIES_MIN;
        end else begin
          restore <= max_in;
        end
      end
    end
  end

endmodule

/* sv/kcl_engine.sv */
`timescale 1ns / 1ps

// Input register, entry/tries state and result register.
module kcl_engine #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEFAULT
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [kcl_pkg::KEY_W-1:0]                    key_code,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [kcl_pkg::SEG_W-1:0]                    segments,
  output logic                                         unlock_pulse,
  output logic                                         locked_out,
  output logic [kcl_pkg::TRIES_W-1:0]                  tries_remaining,
  input  logic                                         cfg_busy,
  input  logic [$clog2(kcl_pkg::pow10(CODE_DIGITS))-1:0] secret_mod,
  input  logic [kcl_pkg::TRIES_W-1:0]                  restore
);

  localparam int MOD_W = $clog2(kcl_pkg::pow10(CODE_DIGITS));
  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int KW    = kcl_pkg::KEY_W;
  localparam int TW    = kcl_pkg::TRIES_W;

  logic          key_v;
  logic [KW-1:0] key_q;
  logic          advance;
  logic          accept;

  logic [KW-1:0] digits      [CODE_DIGITS];
  logic [KW-1:0] digits_next [CODE_DIGITS];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] back_cnt;
  logic [TW-1:0]    tries;
  logic [TW-1:0]    tries_next;
  logic             unlock_next;

  logic             active;
  logic             is_digit;
  logic             complete;
  logic [MOD_W-1:0] entry_val;
  logic             match;

  // Handshake: the input register drains whenever the result register is
  // free or being emptied this cycle.
  assign advance  = key_v && (!out_valid || !out_stall);
  assign in_stall = cfg_busy || (key_v && !advance);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_v <= 1'b0;
    end else if (accept) begin
      key_v <= 1'b1;
    end else if (advance) begin
      key_v <= 1'b0;
    end
    if (accept) begin
      key_q <= key_code;
    end
  end

  assign active   = (tries != '0);
  assign is_digit = (key_q <= kcl_pkg::KEY_DIGIT_MAX);
  assign complete = active && is_digit && (count == CNT_W'(CODE_DIGITS - 1));
  assign back_cnt = count - 1'b1;

  // Entered value, least significant digit first; the last digit is the key.
  always_comb begin
    entry_val = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (i == CODE_DIGITS - 1) begin
        entry_val = entry_val + MOD_W'(key_q) * MOD_W'(kcl_pkg::pow10(i));
      end else begin
        entry_val = entry_val + MOD_W'(digits[i]) * MOD_W'(kcl_pkg::pow10(i));
      end
    end
  end

  assign match = (entry_val == secret_mod);

  always_comb begin
    digits_next = digits;
    count_next  = count;
    tries_next  = tries;
    unlock_next = 1'b0;
    if (active) begin
      case (key_q)
        kcl_pkg::KEY_CLEAR: begin
          for (int i = 0; i < CODE_DIGITS; i++) begin
            digits_next[i] = '0;
          end
          count_next = '0;
        end
        kcl_pkg::KEY_BACK: begin
          if (count != '0) begin
            count_next = back_cnt;
            digits_next[back_cnt[IDX_W-1:0]] = '0;
          end
        end
        default: begin
          if (complete) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              digits_next[i] = '0;
            end
            count_next = '0;
            if (match) begin
              tries_next  = restore;
              unlock_next = 1'b1;
            end else begin
              tries_next = tries - 1'b1;
            end
          end else if (is_digit) begin
            digits_next[count[IDX_W-1:0]] = key_q;
            count_next = count + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        digits[i] <= '0;
      end
      count     <= '0;
      tries     <= kcl_pkg::TRIES_RESET;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        digits    <= digits_next;
        count     <= count_next;
        tries     <= tries_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      segments        <= kcl_pkg::seg_pattern(tries_next);
      unlock_pulse    <= unlock_next;
      locked_out      <= (tries_next == '0);
      tries_remaining <= tries_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count < CNT_W'(CODE_DIGITS))
    else $error("entry count reached the code length");

  a_tries_bound: assert property (@(posedge clk) disable iff (rst)
    tries <= kcl_pkg::TRIES_MAX)
    else $error("tries above nine");

  a_lockout_sticks: assert property (@(posedge clk) disable iff (rst)
    tries == '0 |=> tries == '0)
    else $error("left lockout without reset");

  a_unlock_not_locked: assert property (@(posedge clk) disable iff (rst)
    out_valid && unlock_pulse |-> !locked_out && tries_remaining != '0)
    else $error("unlock reported with no tries");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && tries_remaining == tries)
    else $error("result register not loaded from state");

endmodule

/* tb/keypad_code_lock_core_tb.sv */
`timescale 1ns / 1ps

module keypad_code_lock_core_tb;

  // Keys that do nothing: 12 is "no key", 13-15 are undefined and act the same
  localparam logic [kcl_pkg::KEY_W-1:0] KEY_NONE     = 4'd12;
  localparam logic [kcl_pkg::KEY_W-1:0] KEY_UNDEF_HI = 4'd15;
  localparam int NUM_DIGITS    = kcl_pkg::CODE_DIGITS_DEFAULT;
  localparam int PHASE_KEYS    = 80;    // counted keys per random phase
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES  = 10;

  // Active-low digit patterns for the display, indexed by tries left
  localparam logic [kcl_pkg::SEG_W-1:0] SEG_TABLE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    logic [kcl_pkg::SEG_W-1:0]   segments;
    logic                        unlock;
    logic                        locked;
    logic [kcl_pkg::TRIES_W-1:0] tries;
  } lock_result_t;

  // Lock state mirror plus the queue of display/unlock results still owed by
  // the block. note_key() advances the mirror by one key transaction.
  class lock_scoreboard;
    logic [kcl_pkg::SECRET_W-1:0]    secret;
    logic [kcl_pkg::MAX_TRIES_W-1:0] max_tries;
    logic [kcl_pkg::KEY_W-1:0]       digits [NUM_DIGITS];
    int unsigned                     count;
    logic [kcl_pkg::TRIES_W-1:0]     tries;
    lock_result_t                    owed_q [$];
    int                              errors;
    int                              checked;
    int                              unlocks;
    int                              locked_seen;

    function new();
      secret    = '0;
      max_tries = kcl_pkg::TRIES_RESET;
      tries     = kcl_pkg::TRIES_RESET;
      errors    = 0;
      checked   = 0;
      unlocks   = 0;
      locked_seen = 0;
      clear_entry();
    endfunction

    function void clear_entry();
      foreach (digits[i]) digits[i] = '0;
      count = 0;
    endfunction

    function void set_reg(logic [kcl_pkg::CFG_IDX_W-1:0] idx,
                          logic [kcl_pkg::CFG_DATA_W-1:0] data);
      if (idx == kcl_pkg::CFG_SECRET_CODE) secret = data[kcl_pkg::SECRET_W-1:0];
      else if (idx == kcl_pkg::CFG_MAX_TRIES) max_tries = data[kcl_pkg::MAX_TRIES_W-1:0];
    endfunction

    function logic [kcl_pkg::KEY_W-1:0] secret_digit(int pos);
      int unsigned rest;
      rest = 32'(secret);
      repeat (pos) rest = rest / 10;
      return kcl_pkg::KEY_W'(rest % 10);
    endfunction

    // true when the digits typed so far agree with the code
    function bit prefix_ok();
      for (int unsigned i = 0; i < count; i++)
        if (digits[i] != secret_digit(i)) return 1'b0;
      return 1'b1;
    endfunction

    function logic [kcl_pkg::TRIES_W-1:0] restored_tries();
      if (max_tries > kcl_pkg::TRIES_MAX) return kcl_pkg::TRIES_MAX;
      if (max_tries == 0) return kcl_pkg::TRIES_MIN;
      return max_tries;
    endfunction

    function void note_key(logic [kcl_pkg::KEY_W-1:0] key);
      lock_result_t r;
      r.unlock = 1'b0;
      if (tries != 0) begin
        if (key == kcl_pkg::KEY_CLEAR) begin
          clear_entry();
        end else if (key == kcl_pkg::KEY_BACK) begin
          if (count > 0) begin
            count--;
            digits[count] = '0;
          end
        end else if (key <= kcl_pkg::KEY_DIGIT_MAX) begin
          if (count < NUM_DIGITS) begin
            digits[count] = key;
            count++;
          end
        end
        if (count >= NUM_DIGITS) begin
          if (prefix_ok()) begin
            tries    = restored_tries();
            r.unlock = 1'b1;
          end else begin
            tries = tries - 1'b1;
          end
          clear_entry();
        end
      end
      r.segments = SEG_TABLE[tries];
      r.locked   = (tries == 0);
      r.tries    = tries;
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("[%0t] mismatch %0d: %s got %0h want %0h",
               $time, errors, what, got, want);
    endtask

    task check_result(lock_result_t got);
      lock_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result with nothing pending", got, 0);
      end else begin
        want = owed_q.pop_front();
        checked++;
        if (got.segments != want.segments)
          report_mismatch("segments", got.segments, want.segments);
        if (got.unlock != want.unlock)
          report_mismatch("unlock_pulse", got.unlock, want.unlock);
        if (got.locked != want.locked)
          report_mismatch("locked_out", got.locked, want.locked);
        if (got.tries != want.tries)
          report_mismatch("tries_remaining", got.tries, want.tries);
        if (want.unlock) unlocks++;
        if (want.locked) locked_seen++;
      end
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // DUT signals; the driven inputs are all known from time zero
  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              cfg_we    = 1'b0;
  logic [kcl_pkg::CFG_IDX_W-1:0]     cfg_index = kcl_pkg::CFG_SECRET_CODE;
  logic [kcl_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_stall;
  logic [kcl_pkg::KEY_W-1:0]         key_code  = KEY_NONE;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [kcl_pkg::SEG_W-1:0]         segments;
  logic                              unlock_pulse;
  logic                              locked_out;
  logic [kcl_pkg::TRIES_W-1:0]       tries_remaining;

  lock_scoreboard sb = new();

  int  burst_left    = 0;
  int  keys_sent     = 0;   // keys the lock actually acts on
  int  cfg_writes    = 0;
  int  idle_cycles   = 0;
  int  backpressured = 0;   // cycles the block refused an offered key
  int  long_holds    = 0;
  bit  hold_req      = 1'b0;
  bit  allow_lockout = 1'b0;

  keypad_code_lock_core u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .key_code        (key_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .segments        (segments),
    .unlock_pulse    (unlock_pulse),
    .locked_out      (locked_out),
    .tries_remaining (tries_remaining)
  );

  always #5 clk = ~clk;

  // Until the closing phase, a wrong fourth digit on the last try would lock
  // the block for good (only reset leaves lockout), so turn it into a clear.
  function automatic logic [kcl_pkg::KEY_W-1:0] guard_key(logic [kcl_pkg::KEY_W-1:0] k);
    if (!allow_lockout && sb.tries == 1 && sb.count == NUM_DIGITS - 1 &&
        k <= kcl_pkg::KEY_DIGIT_MAX &&
        !(sb.prefix_ok() && k == sb.secret_digit(NUM_DIGITS - 1)))
      return kcl_pkg::KEY_CLEAR;
    return k;
  endfunction

  // One key transaction. The sender runs in bursts; at the end of a burst it
  // drops valid for a random gap and picks the next burst length.
  task automatic send_key(input logic [kcl_pkg::KEY_W-1:0] k);
    logic [kcl_pkg::KEY_W-1:0] key;
    int gap;
    key = guard_key(k);
    @(negedge clk);
    in_valid <= 1'b1;
    key_code <= key;
    do @(posedge clk); while (in_stall);
    if (key <= kcl_pkg::KEY_BACK && sb.tries != 0) keys_sent++;
    sb.note_key(key);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Register write only with the pipe empty: stop sending, wait for every owed
  // result and let the two pipeline stages settle before the write goes out.
  task automatic write_reg(input logic [kcl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kcl_pkg::CFG_DATA_W-1:0] data);
    stop_sending();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic set_lock(input logic [kcl_pkg::SECRET_W-1:0] code,
                          input logic [kcl_pkg::MAX_TRIES_W-1:0] mt);
    write_reg(kcl_pkg::CFG_SECRET_CODE, kcl_pkg::CFG_DATA_W'(code));
    write_reg(kcl_pkg::CFG_MAX_TRIES, kcl_pkg::CFG_DATA_W'(mt));
  endtask

  // Type the code from wherever the entry stands now
  task automatic type_secret();
    repeat (NUM_DIGITS) send_key(sb.secret_digit(sb.count));
  endtask

  // One random sequence: mostly well-formed code entries with noise mixed in
  task automatic random_sequence();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      // right code, with stray no-key ticks and typo+backspace fixes
      repeat (NUM_DIGITS) begin
        if ($urandom_range(0, 4) == 0)
          send_key(kcl_pkg::KEY_W'($urandom_range(KEY_NONE, KEY_UNDEF_HI)));
        if ($urandom_range(0, 7) == 0) begin
          send_key(kcl_pkg::KEY_W'($urandom_range(0, kcl_pkg::KEY_DIGIT_MAX)));
          send_key(kcl_pkg::KEY_BACK);
        end
        send_key(sb.secret_digit(sb.count));
      end
    end else if (pick <= 6) begin
      // random digits; almost always a wrong code
      repeat (NUM_DIGITS) begin
        if ($urandom_range(0, 5) == 0)
          send_key(kcl_pkg::KEY_W'($urandom_range(KEY_NONE, KEY_UNDEF_HI)));
        send_key(kcl_pkg::KEY_W'($urandom_range(0, kcl_pkg::KEY_DIGIT_MAX)));
      end
    end else if (pick == 7) begin
      // abandoned entry
      repeat ($urandom_range(1, NUM_DIGITS - 1))
        send_key(kcl_pkg::KEY_W'($urandom_range(0, kcl_pkg::KEY_DIGIT_MAX)));
      if ($urandom_range(0, 1)) send_key(kcl_pkg::KEY_CLEAR);
      else repeat ($urandom_range(1, NUM_DIGITS)) send_key(kcl_pkg::KEY_BACK);
    end else begin
      repeat ($urandom_range(1, 6)) send_key(kcl_pkg::KEY_W'($urandom_range(0, 15)));
    end
  endtask

  task automatic random_phase(input logic [kcl_pkg::SECRET_W-1:0] code,
                              input logic [kcl_pkg::MAX_TRIES_W-1:0] mt,
                              input bit with_hold);
    int target;
    set_lock(code, mt);
    // the long hold-off starts only once keys are flowing again
    if (with_hold) hold_req = 1'b1;
    target = keys_sent + PHASE_KEYS;
    while (keys_sent < target) random_sequence();
  endtask

  // Result monitor: sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(lock_result_t'({segments, unlock_pulse, locked_out, tries_remaining}));
  end

  // Watchdog on lack of progress, plus a count of input backpressure
  always @(posedge clk) begin
    if (!rst && in_valid && in_stall) backpressured++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results owed",
               IDLE_LIMIT, sb.pending());
      $display("FAIL keypad_code_lock_core");
      $finish;
    end
  end

  // Receiver stall pattern: free-running stretches, random stalls, short solid
  // stalls, and on request one long hold-off that lets the block fill up.
  initial begin : receiver
    int mode;
    int len;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        long_holds++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(1, 30);
      repeat (len) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= 1'b1;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int target;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset code 0 with five tries. No-key and undefined codes,
    // backspace and clear on an empty entry, then a partial entry undone.
    send_key(KEY_NONE);
    send_key(KEY_UNDEF_HI);
    send_key(kcl_pkg::KEY_BACK);
    send_key(kcl_pkg::KEY_CLEAR);
    send_key(4'd1);
    send_key(4'd2);
    send_key(kcl_pkg::KEY_BACK);
    send_key(kcl_pkg::KEY_CLEAR);
    // reset code 0000 unlocks
    repeat (NUM_DIGITS) send_key(4'd0);
    // 3,9,back,0,0,0 -> 3000: wrong code costs a try
    send_key(4'd3);
    send_key(4'd9);
    send_key(kcl_pkg::KEY_BACK);
    repeat (NUM_DIGITS - 1) send_key(4'd0);

    // widest code (reduced to its low four decimal digits), most tries
    set_lock(16'hFFFF, kcl_pkg::TRIES_MAX);
    type_secret();
    // max_tries 0 restores a single try
    write_reg(kcl_pkg::CFG_MAX_TRIES, '0);
    type_secret();
    // max_tries above nine saturates at nine
    write_reg(kcl_pkg::CFG_MAX_TRIES, kcl_pkg::CFG_DATA_W'(4'hF));
    type_secret();

    // Random phases over several settings, extremes among them
    write_reg(kcl_pkg::CFG_MAX_TRIES, kcl_pkg::CFG_DATA_W'(kcl_pkg::TRIES_MAX));
    target = keys_sent + 40;
    while (keys_sent < target) random_sequence();
    // first phase: long receiver hold while keys keep coming
    random_phase(kcl_pkg::SECRET_W'($urandom_range(0, 65535)),
                 kcl_pkg::MAX_TRIES_W'($urandom_range(1, 9)), 1'b1);
    random_phase(16'd9999, kcl_pkg::TRIES_MIN, 1'b0);
    random_phase(kcl_pkg::SECRET_W'($urandom_range(0, 65535)), '0, 1'b0);
    random_phase(16'd10000, kcl_pkg::MAX_TRIES_W'($urandom_range(1, 9)), 1'b0);
    random_phase(kcl_pkg::SECRET_W'($urandom_range(0, 65535)), 4'hF, 1'b0);
    random_phase(16'd0, kcl_pkg::MAX_TRIES_W'($urandom_range(1, 9)), 1'b0);

    // Closing phase: wrong codes until lockout, then keys that must be ignored
    set_lock(kcl_pkg::SECRET_W'($urandom_range(0, 65535)),
             kcl_pkg::MAX_TRIES_W'($urandom_range(1, 9)));
    allow_lockout = 1'b1;
    send_key(kcl_pkg::KEY_CLEAR);
    while (sb.tries != 0) begin
      send_key(kcl_pkg::KEY_W'((sb.secret_digit(0) + 1) % 10));
      repeat (NUM_DIGITS - 1)
        send_key(kcl_pkg::KEY_W'($urandom_range(0, kcl_pkg::KEY_DIGIT_MAX)));
    end
    type_secret();
    send_key(kcl_pkg::KEY_CLEAR);
    repeat (20) send_key(kcl_pkg::KEY_W'($urandom_range(0, 15)));

    stop_sending();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d live keys, %0d results checked, %0d unlocks, %0d locked-out ticks",
             keys_sent, sb.checked, sb.unlocks, sb.locked_seen);
    $display("     %0d register writes, %0d long hold-offs, %0d cycles of input backpressure",
             cfg_writes, long_holds, backpressured);
    if (sb.errors == 0) begin
      $display("PASS keypad_code_lock_core");
    end else begin
      $display("FAIL keypad_code_lock_core");
    end
    $finish;
  end

endmodule

/* files.f */
sv/kcl_pkg.sv
sv/kcl_config.sv
sv/kcl_engine.sv
sv/keypad_code_lock_core.sv
tb/keypad_code_lock_core_tb.sv
